// ----- rtl/zb32_pkg.sv -----
package zb32_pkg;

	localparam int LENGTH_WIDTH_DEF = 16;
	localparam int ACC_BITS = 12;
	localparam int HELD_W = $clog2(ACC_BITS + 1);
	localparam int ENC_W = 5;
	localparam int DEC_W = 8;
	localparam int SENT_W = 16;
	localparam int MAX_RES = 3;
	localparam int RES_CNT_W = $clog2(MAX_RES + 1);
	localparam int RES_IDX_W = $clog2(MAX_RES);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		OP_ENCODE = 1'b0,
		OP_DECODE = 1'b1
	} op_t;

	typedef struct packed {
		logic [RES_CNT_W-1:0] cnt;
		logic [MAX_RES-1:0][7:0] sym;
		logic inv;
		logic last;
	} zb32_job_t;

	typedef struct packed {
		logic bad;
		logic [ENC_W-1:0] val;
	} rev_t;

	function automatic logic [ACC_BITS-1:0] low_mask(logic [HELD_W-1:0] n);
		return ~({ACC_BITS{1'b1}} << n);
	endfunction

	function automatic logic [7:0] alpha_char(logic [ENC_W-1:0] idx);
		logic [7:0] ch;
		unique case (idx)
			5'd0: ch = "y";
			5'd1: ch = "b";
			5'd2: ch = "n";
			5'd3: ch = "d";
			5'd4: ch = "r";
			5'd5: ch = "f";
			5'd6: ch = "g";
			5'd7: ch = "8";
			5'd8: ch = "e";
			5'd9: ch = "j";
			5'd10: ch = "k";
			5'd11: ch = "m";
			5'd12: ch = "c";
			5'd13: ch = "p";
			5'd14: ch = "q";
			5'd15: ch = "x";
			5'd16: ch = "o";
			5'd17: ch = "t";
			5'd18: ch = "1";
			5'd19: ch = "u";
			5'd20: ch = "w";
			5'd21: ch = "i";
			5'd22: ch = "s";
			5'd23: ch = "z";
			5'd24: ch = "a";
			5'd25: ch = "3";
			5'd26: ch = "4";
			5'd27: ch = "5";
			5'd28: ch = "h";
			5'd29: ch = "7";
			5'd30: ch = "6";
			default: ch = "9";
		endcase
		return ch;
	endfunction

	function automatic rev_t rev_lookup(logic [7:0] ch);
		rev_t r;
		r.bad = 1'b0;
		unique case (ch)
			"y": r.val = 5'd0;
			"b": r.val = 5'd1;
			"n": r.val = 5'd2;
			"d": r.val = 5'd3;
			"r": r.val = 5'd4;
			"f": r.val = 5'd5;
			"g": r.val = 5'd6;
			"8": r.val = 5'd7;
			"e": r.val = 5'd8;
			"j": r.val = 5'd9;
			"k": r.val = 5'd10;
			"m": r.val = 5'd11;
			"c": r.val = 5'd12;
			"p": r.val = 5'd13;
			"q": r.val = 5'd14;
			"x": r.val = 5'd15;
			"o": r.val = 5'd16;
			"t": r.val = 5'd17;
			"1": r.val = 5'd18;
			"u": r.val = 5'd19;
			"w": r.val = 5'd20;
			"i": r.val = 5'd21;
			"s": r.val = 5'd22;
			"z": r.val = 5'd23;
			"a": r.val = 5'd24;
			"3": r.val = 5'd25;
			"4": r.val = 5'd26;
			"5": r.val = 5'd27;
			"h": r.val = 5'd28;
			"7": r.val = 5'd29;
			"6": r.val = 5'd30;
			"9": r.val = 5'd31;
			default: begin
				r.val = 5'd0;
				r.bad = 1'b1;
			end
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/zb32_if.sv -----
interface zb32_in_if #(parameter int LENGTH_WIDTH = zb32_pkg::LENGTH_WIDTH_DEF);
	logic valid;
	logic ready;
	logic operation;
	logic [7:0] data;
	logic last;
	logic [LENGTH_WIDTH-1:0] total_bits;

	modport source (output valid, operation, data, last, total_bits, input ready);
	modport sink (input valid, operation, data, last, total_bits, output ready);
endinterface

interface zb32_out_if;
	logic valid;
	logic ready;
	logic [7:0] symbol;
	logic last_out;
	logic invalid;

	modport source (output valid, symbol, last_out, invalid, input ready);
	modport sink (input valid, symbol, last_out, invalid, output ready);
endinterface

// ----- rtl/zbase32_codec_core.sv -----
// A result passes through the job queue and then the output register before it is ready for transfer.
// Throughput: one input item per cycle while the queue has room; one result per cycle
//   while dout.ready takes it. An item yields 0 to 3 results, one output transfer each.
// A 2-entry job queue lets the input side run ahead while results wait on the output.
// Reset: arst_n clears the bit accumulator, counters, error flag, queue and output valid.
module zbase32_codec_core #(
	parameter int LENGTH_WIDTH = zb32_pkg::LENGTH_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	zb32_in_if.sink din,
	zb32_out_if.source dout
);
	import zb32_pkg::*;

	logic push;
	logic full;
	logic head_valid;
	logic pop;
	zb32_job_t push_job;
	zb32_job_t head;

	zb32_front #(
		.LENGTH_WIDTH(LENGTH_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.din(din),
		.full(full),
		.push(push),
		.push_job(push_job)
	);

	zb32_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.full(full),
		.head_valid(head_valid),
		.head(head),
		.pop(pop)
	);

	zb32_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head(head),
		.pop(pop),
		.dout(dout)
	);

endmodule

// ----- rtl/zb32_front.sv -----
module zb32_front #(
	parameter int LENGTH_WIDTH = zb32_pkg::LENGTH_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	zb32_in_if.sink din,
	input logic full,
	output logic push,
	output zb32_pkg::zb32_job_t push_job
);
	import zb32_pkg::*;

	localparam int CMP_W = (LENGTH_WIDTH > SENT_W + 3) ? LENGTH_WIDTH : SENT_W + 3;

	logic [ACC_BITS-1:0] acc_q;
	logic [HELD_W-1:0] held_q;
	logic [SENT_W-1:0] sent_q;
	logic err_q;

	logic accept;
	logic dec;
	rev_t rv;
	logic err_n;
	logic [HELD_W-1:0] w;
	logic [HELD_W-1:0] room;
	logic [HELD_W-1:0] h0;
	logic [HELD_W-1:0] h1;
	logic [HELD_W-1:0] h2;
	logic [ACC_BITS-1:0] kept;
	logic [ACC_BITS-1:0] acc1;
	logic [ACC_BITS-1:0] acc2;
	logic [RES_CNT_W-1:0] ngrp;
	logic [RES_CNT_W-1:0] ncand;
	logic [RES_CNT_W-1:0] nok;
	logic [RES_CNT_W-1:0] nemit;
	logic [7:0] grp0;
	logic [7:0] grp1;
	logic [7:0] pad;
	logic [MAX_RES-1:0][7:0] cand;
	logic [MAX_RES-1:0] ok;
	logic [SENT_W:0] sum;
	logic [SENT_W-1:0] sent_n;
	logic [CMP_W-1:0] len;

	assign accept = din.valid && din.ready;
	assign din.ready = !full;

	always_comb begin
		dec = (din.operation == OP_DECODE);
		rv = rev_lookup(din.data);
		err_n = err_q | (dec & rv.bad);
		w = dec ? HELD_W'(ENC_W) : HELD_W'(DEC_W);
		room = HELD_W'(ACC_BITS) - w;
		h0 = (held_q > room) ? room : held_q;
		kept = acc_q & low_mask(h0);
		if (dec) begin
			acc1 = (kept << ENC_W) | ACC_BITS'(rv.val);
		end else begin
			acc1 = (kept << DEC_W) | ACC_BITS'(din.data);
		end
		h1 = h0 + w;
		grp1 = '0;
		if (dec) begin
			ngrp = (h1 >= HELD_W'(DEC_W)) ? RES_CNT_W'(1) : RES_CNT_W'(0);
			grp0 = 8'(acc1 >> (h1 - HELD_W'(DEC_W)));
			h2 = (ngrp != '0) ? h1 - HELD_W'(DEC_W) : h1;
		end else begin
			if (h1 >= HELD_W'(2 * ENC_W)) begin
				ngrp = RES_CNT_W'(2);
				h2 = h1 - HELD_W'(2 * ENC_W);
			end else if (h1 >= HELD_W'(ENC_W)) begin
				ngrp = RES_CNT_W'(1);
				h2 = h1 - HELD_W'(ENC_W);
			end else begin
				ngrp = '0;
				h2 = h1;
			end
			grp0 = alpha_char(ENC_W'(acc1 >> (h1 - HELD_W'(ENC_W))));
			grp1 = alpha_char(ENC_W'(acc1 >> (h1 - HELD_W'(2 * ENC_W))));
		end
		acc2 = acc1 & low_mask(h2);
		if (dec) begin
			pad = 8'(acc2 << (HELD_W'(DEC_W) - h2));
		end else begin
			pad = alpha_char(ENC_W'(acc2 << (HELD_W'(ENC_W) - h2)));
		end
		cand[0] = (ngrp == RES_CNT_W'(0)) ? pad : grp0;
		cand[1] = (ngrp == RES_CNT_W'(1)) ? pad : grp1;
		cand[2] = pad;
		ncand = ngrp + RES_CNT_W'(din.last && (h2 != '0));
	end

	assign len = CMP_W'(din.total_bits);

	for (genvar j = 0; j < MAX_RES; j++) begin : g_cap
		logic [SENT_W:0] raw;
		logic [SENT_W-1:0] nj;
		logic [CMP_W-1:0] scaled;
		always_comb begin
			raw = {1'b0, sent_q} + (SENT_W + 1)'(j);
			nj = raw[SENT_W] ? {SENT_W{1'b1}} : raw[SENT_W-1:0];
			if (dec) begin
				scaled = CMP_W'(nj) << 3;
			end else begin
				scaled = (CMP_W'(nj) << 2) + CMP_W'(nj);
			end
		end
		assign ok[j] = (scaled < len);
	end

	always_comb begin
		nok = !ok[0] ? RES_CNT_W'(0) : !ok[1] ? RES_CNT_W'(1) :
			!ok[2] ? RES_CNT_W'(2) : RES_CNT_W'(3);
		nemit = (nok < ncand) ? nok : ncand;
		sum = {1'b0, sent_q} + (SENT_W + 1)'(nemit);
		sent_n = sum[SENT_W] ? {SENT_W{1'b1}} : sum[SENT_W-1:0];
	end

	assign push = accept && (nemit != '0);

	always_comb begin
		push_job.cnt = nemit;
		push_job.sym = cand;
		push_job.inv = dec & err_n;
		push_job.last = din.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			held_q <= '0;
			sent_q <= '0;
			err_q <= 1'b0;
		end else if (accept) begin
			if (din.last) begin
				acc_q <= '0;
				held_q <= '0;
				sent_q <= '0;
				err_q <= 1'b0;
			end else begin
				acc_q <= acc2;
				held_q <= h2;
				sent_q <= sent_n;
				err_q <= err_n;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) held_q <= HELD_W'(ACC_BITS))
		else $error("pending bit count above accumulator size");

endmodule

// ----- rtl/zb32_queue.sv -----
module zb32_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input zb32_pkg::zb32_job_t push_job,
	output logic full,
	output logic head_valid,
	output zb32_pkg::zb32_job_t head,
	input logic pop
);
	import zb32_pkg::*;

	zb32_job_t slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wp_q;
	logic [QPTR_W-1:0] rp_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into full queue");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> head_valid)
		else $error("pop from empty queue");

endmodule

// ----- rtl/zb32_back.sv -----
module zb32_back (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input zb32_pkg::zb32_job_t head,
	output logic pop,
	zb32_out_if.source dout
);
	import zb32_pkg::*;

	logic [RES_IDX_W-1:0] idx_q;
	logic ov_q;
	logic [7:0] sym_q;
	logic last_q;
	logic inv_q;

	logic load;
	logic final_res;

	assign load = head_valid && (!ov_q || dout.ready);
	assign final_res = (RES_CNT_W'(idx_q) == head.cnt - 1'b1);
	assign pop = load && final_res;

	assign dout.valid = ov_q;
	assign dout.symbol = sym_q;
	assign dout.last_out = last_q;
	assign dout.invalid = inv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			ov_q <= 1'b0;
		end else if (load) begin
			ov_q <= 1'b1;
			idx_q <= final_res ? '0 : idx_q + 1'b1;
		end else if (dout.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sym_q <= head.sym[idx_q];
			last_q <= head.last && final_res;
			inv_q <= head.inv;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) head_valid |-> head.cnt != '0)
		else $error("queued job without results");
	assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> RES_CNT_W'(idx_q) < head.cnt)
		else $error("result index past job count");

endmodule
